FILE: hw/rtl/srt_pkg.sv
// Shared types, sizes and codes for the sorted record table.
package srt_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;

    // Fixed port field widths
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int KEYP_W  = 16;
    localparam int STOPS_W = 8;
    localparam int TIME_W  = 16;
    localparam int ENT_W   = 5;

    // Derived widths: stored key keeps only the key bits the port can carry
    localparam int KEY_W = (KEY_BITS < KEYP_W) ? KEY_BITS : KEYP_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int REC_W = KEY_W + STOPS_W + TIME_W;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STOPS_W-1:0] stops;
        logic [TIME_W-1:0]  ride;
    } t_rec;

    // Operands of the shared key compare unit
    typedef struct packed {
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
    } t_cmp_in;

    // Flags from the shared key compare unit
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_out;

endpackage

FILE: hw/rtl/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/srt_cmp.sv
// Shared key compare unit used by every scan step.
module srt_cmp (
    input  srt_pkg::t_cmp_in  i_op,
    output srt_pkg::t_cmp_out o_res
);

    // a < b drives the insert scan, a == b the delete scan
    always_comb begin
        o_res.lt = (i_op.a < i_op.b);
        o_res.eq = (i_op.a == i_op.b);
    end

endmodule

FILE: hw/rtl/sorted_record_table_unit.sv
// Sorted record table: sequencer over one record RAM and one key compare unit.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+--------------------------
//  command  | i_action i_key i_stop_count i_ride_time        | taken on start && !busy
//  result   | o_status o_out_key o_out_stops o_out_time      | o_valid, one cycle each
//           | o_entries_held o_last                          |
//
//  Entries are handled one at a time: insert scans the entries below the new key, shifts
//  the rest up and writes the new record; delete scans through the match and shifts the
//  entries above it down; a delete miss scans every held entry; dump reads and returns each
//  held entry. Full insert, empty dump and code 3 go straight to the result. busy drops
//  after the last result; reset (synchronous, active low) empties the table. The result
//  side cannot stall: each word stands one cycle.
module sorted_record_table_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [srt_pkg::ACT_W-1:0]    i_action,
    input  logic [srt_pkg::KEYP_W-1:0]   i_key,
    input  logic [srt_pkg::STOPS_W-1:0]  i_stop_count,
    input  logic [srt_pkg::TIME_W-1:0]   i_ride_time,
    output logic                         o_valid,
    output logic [srt_pkg::STAT_W-1:0]   o_status,
    output logic [srt_pkg::KEYP_W-1:0]   o_out_key,
    output logic [srt_pkg::STOPS_W-1:0]  o_out_stops,
    output logic [srt_pkg::TIME_W-1:0]   o_out_time,
    output logic [srt_pkg::ENT_W-1:0]    o_entries_held,
    output logic                         o_last
);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_INS_RD   = 4'd3;
    localparam logic [3:0] S_INS_WR   = 4'd4;
    localparam logic [3:0] S_INS_NEW  = 4'd5;
    localparam logic [3:0] S_DEL_RD   = 4'd6;
    localparam logic [3:0] S_DEL_WR   = 4'd7;
    localparam logic [3:0] S_DUMP_RD  = 4'd8;
    localparam logic [3:0] S_DUMP_OUT = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    localparam logic [srt_pkg::CNT_W-1:0] FULL_CNT = srt_pkg::CNT_W'(srt_pkg::TABLE_DEPTH);
    localparam logic [srt_pkg::CNT_W-1:0] ONE_CNT  = srt_pkg::CNT_W'(1);

    logic [3:0]                       r_state,  n_state;
    logic [srt_pkg::CNT_W-1:0]        r_fill,   n_fill;
    logic [srt_pkg::CNT_W-1:0]        r_idx,    n_idx;
    logic [srt_pkg::CNT_W-1:0]        r_pos,    n_pos;
    logic [srt_pkg::STAT_W-1:0]       r_status, n_status;
    logic [srt_pkg::ACT_W-1:0]        r_action;
    srt_pkg::t_rec                    r_rec;

    logic                             w_accept;
    logic [srt_pkg::CNT_W-1:0]        w_idx_dn;
    logic [srt_pkg::CNT_W-1:0]        w_idx_up;
    logic                             w_we;
    logic [srt_pkg::IDX_W-1:0]        w_waddr;
    srt_pkg::t_rec                    w_wdata;
    logic [srt_pkg::IDX_W-1:0]        w_raddr;
    srt_pkg::t_rec                    w_rdata;
    srt_pkg::t_cmp_in                 w_cmp_in;
    srt_pkg::t_cmp_out                w_cmp_out;
    logic                             w_dump_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_idx_dn = r_idx - ONE_CNT;
    assign w_idx_up = r_idx + ONE_CNT;
    assign w_dump_last = (w_idx_up == r_fill);

    // Record storage
    srt_ram #(
        .WIDTH (srt_pkg::REC_W),
        .DEPTH (srt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared compare: stored key against command key
    assign w_cmp_in.a = w_rdata.key;
    assign w_cmp_in.b = r_rec.key;

    srt_cmp u_cmp (
        .i_op  (w_cmp_in),
        .o_res (w_cmp_out)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_idx[srt_pkg::IDX_W-1:0];
        w_wdata  = w_rdata;
        w_raddr  = r_idx[srt_pkg::IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                n_idx    = '0;
                n_status = srt_pkg::ST_OK;
                if (w_accept) begin
                    case (i_action)
                        srt_pkg::ACT_INSERT: begin
                            if (r_fill == FULL_CNT) begin
                                n_status = srt_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        srt_pkg::ACT_DELETE: n_state = S_SCAN_RD;
                        srt_pkg::ACT_DUMP: begin
                            if (r_fill == '0) begin
                                n_status = srt_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_DUMP_RD;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // Scan: read entry, then compare it
            S_SCAN_RD: begin
                if (r_idx == r_fill) begin
                    if (r_action == srt_pkg::ACT_INSERT) begin
                        n_pos   = r_idx;
                        n_idx   = r_fill;
                        n_state = S_INS_RD;
                    end else begin
                        n_status = srt_pkg::ST_NOTFOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (r_action == srt_pkg::ACT_INSERT) begin
                    if (!w_cmp_out.lt) begin
                        n_pos   = r_idx;
                        n_idx   = r_fill;
                        n_state = S_INS_RD;
                    end else begin
                        n_idx   = w_idx_up;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    if (w_cmp_out.eq) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_idx   = w_idx_up;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            // Insert: move entries up one place from the top down to pos
            S_INS_RD: begin
                w_raddr = w_idx_dn[srt_pkg::IDX_W-1:0];
                if (r_idx == r_pos) begin
                    n_state = S_INS_NEW;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                n_idx   = w_idx_dn;
                n_state = S_INS_RD;
            end
            S_INS_NEW: begin
                w_we    = 1'b1;
                w_waddr = r_pos[srt_pkg::IDX_W-1:0];
                w_wdata = r_rec;
                n_fill  = r_fill + ONE_CNT;
                n_state = S_DONE;
            end
            // Delete: move entries above the match down one place
            S_DEL_RD: begin
                w_raddr = w_idx_up[srt_pkg::IDX_W-1:0];
                if (w_idx_up >= r_fill) begin
                    n_fill  = r_fill - ONE_CNT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                w_we    = 1'b1;
                n_idx   = w_idx_up;
                n_state = S_DEL_RD;
            end
            // Dump: one entry per read and result pair
            S_DUMP_RD: n_state = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (w_dump_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = w_idx_up;
                    n_state = S_DUMP_RD;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Working registers and latched command word
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        if (w_accept) begin
            r_action    <= i_action;
            r_rec.key   <= i_key[srt_pkg::KEY_W-1:0];
            r_rec.stops <= i_stop_count;
            r_rec.ride  <= i_ride_time;
        end
    end

    // Result word
    always_comb begin
        o_valid        = 1'b0;
        o_status       = r_status;
        o_out_key      = '0;
        o_out_stops    = '0;
        o_out_time     = '0;
        o_entries_held = srt_pkg::ENT_W'(r_fill);
        o_last         = 1'b0;
        if (r_state == S_DONE) begin
            o_valid = 1'b1;
            o_last  = 1'b1;
        end else if (r_state == S_DUMP_OUT) begin
            o_valid     = 1'b1;
            o_status    = srt_pkg::ST_OK;
            o_out_key   = srt_pkg::KEYP_W'(w_rdata.key);
            o_out_stops = w_rdata.stops;
            o_out_time  = w_rdata.ride;
            o_last      = w_dump_last;
        end
    end

    // Checks
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word outside a command");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but sequencer stayed idle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("sequencer still busy after final result");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond table depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == srt_pkg::ST_FULL)) |-> (r_fill == FULL_CNT))
        else $error("full status with room left");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sorted record table: directed and random commands.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block does not define; it must be ignored
    localparam logic [srt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_CMDS    = 250;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // One command word as driven on the ports
    typedef struct packed {
        logic [srt_pkg::ACT_W-1:0]   act;
        logic [srt_pkg::KEYP_W-1:0]  key;
        logic [srt_pkg::STOPS_W-1:0] stops;
        logic [srt_pkg::TIME_W-1:0]  ride;
    } t_cmd;

    // One result word, field order matches the port list
    typedef struct packed {
        logic [srt_pkg::STAT_W-1:0]  status;
        logic [srt_pkg::KEYP_W-1:0]  key;
        logic [srt_pkg::STOPS_W-1:0] stops;
        logic [srt_pkg::TIME_W-1:0]  ride;
        logic [srt_pkg::ENT_W-1:0]   held;
        logic                        last;
    } t_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [srt_pkg::ACT_W-1:0]    i_action;
    logic [srt_pkg::KEYP_W-1:0]   i_key;
    logic [srt_pkg::STOPS_W-1:0]  i_stop_count;
    logic [srt_pkg::TIME_W-1:0]   i_ride_time;
    logic                         o_valid;
    logic [srt_pkg::STAT_W-1:0]   o_status;
    logic [srt_pkg::KEYP_W-1:0]   o_out_key;
    logic [srt_pkg::STOPS_W-1:0]  o_out_stops;
    logic [srt_pkg::TIME_W-1:0]   o_out_time;
    logic [srt_pkg::ENT_W-1:0]    o_entries_held;
    logic                         o_last;

    sorted_record_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_stop_count   (i_stop_count),
        .i_ride_time    (i_ride_time),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_key      (o_out_key),
        .o_out_stops    (o_out_stops),
        .o_out_time     (o_out_time),
        .o_entries_held (o_entries_held),
        .o_last         (o_last)
    );

    // Shadow copy of the record table
    logic [srt_pkg::KEY_W-1:0]   tbl_key   [srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::STOPS_W-1:0] tbl_stops [srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::TIME_W-1:0]  tbl_ride  [srt_pkg::TABLE_DEPTH];
    int                          tbl_fill;

    t_cmd                       cmd_queue[$];
    t_result                    pending_results[$];
    logic [srt_pkg::KEYP_W-1:0] gen_keys[$];    // keys the generator believes are held

    int  total_cmds;
    int  issued_count;
    int  taken_count;
    int  checked_count;
    int  err_count;
    int  stall_cycles;
    int  gap_left;
    int  burst_left;
    bit  drive_on;

    // Coverage tallies for the summary
    int  n_insert, n_delete, n_dump, n_ignored;
    int  n_full, n_miss, n_rows, n_empty_dump, peak_fill;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Count an error; only the first few are printed
    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] result error: %s", $time, msg);
    endfunction

    // Apply one accepted command to the shadow table and queue the words it yields
    function automatic void predict_table_op(input t_cmd c);
        t_result                   r;
        logic [srt_pkg::KEY_W-1:0] k;
        int                        pos;
        int                        i;
        k = c.key[srt_pkg::KEY_W-1:0];
        r = '0;
        r.last = 1'b1;
        if (c.act == srt_pkg::ACT_DUMP) begin
            n_dump++;
            if (tbl_fill == 0) begin
                n_empty_dump++;
                r.status = srt_pkg::ST_EMPTY;
                pending_results.push_back(r);
            end else begin
                for (i = 0; i < tbl_fill; i++) begin
                    r.status = srt_pkg::ST_OK;
                    r.key    = srt_pkg::KEYP_W'(tbl_key[i]);
                    r.stops  = tbl_stops[i];
                    r.ride   = tbl_ride[i];
                    r.held   = srt_pkg::ENT_W'(tbl_fill);
                    r.last   = (i == tbl_fill - 1);
                    pending_results.push_back(r);
                    n_rows++;
                end
            end
            return;
        end
        if (c.act == srt_pkg::ACT_INSERT) begin
            n_insert++;
            if (tbl_fill >= srt_pkg::TABLE_DEPTH) begin
                r.status = srt_pkg::ST_FULL;
                n_full++;
            end else begin
                // new record goes ahead of any equal keys
                pos = 0;
                while (pos < tbl_fill && tbl_key[pos] < k)
                    pos++;
                for (i = tbl_fill; i > pos; i--) begin
                    tbl_key[i]   = tbl_key[i-1];
                    tbl_stops[i] = tbl_stops[i-1];
                    tbl_ride[i]  = tbl_ride[i-1];
                end
                tbl_key[pos]   = k;
                tbl_stops[pos] = c.stops;
                tbl_ride[pos]  = c.ride;
                tbl_fill++;
                if (tbl_fill > peak_fill)
                    peak_fill = tbl_fill;
            end
        end else if (c.act == srt_pkg::ACT_DELETE) begin
            n_delete++;
            // lowest matching entry is removed
            pos = 0;
            while (pos < tbl_fill && tbl_key[pos] != k)
                pos++;
            if (pos >= tbl_fill) begin
                r.status = srt_pkg::ST_NOTFOUND;
                n_miss++;
            end else begin
                for (i = pos; i + 1 < tbl_fill; i++) begin
                    tbl_key[i]   = tbl_key[i+1];
                    tbl_stops[i] = tbl_stops[i+1];
                    tbl_ride[i]  = tbl_ride[i+1];
                end
                tbl_fill--;
            end
        end else begin
            n_ignored++;
        end
        r.held = srt_pkg::ENT_W'(tbl_fill);
        pending_results.push_back(r);
    endfunction

    // Queue a command and track which keys it leaves held
    function automatic void queue_cmd(input logic [srt_pkg::ACT_W-1:0] act,
                                      input logic [srt_pkg::KEYP_W-1:0] key,
                                      input logic [srt_pkg::STOPS_W-1:0] stops,
                                      input logic [srt_pkg::TIME_W-1:0] ride);
        t_cmd c;
        int   idx;
        c.act   = act;
        c.key   = key;
        c.stops = stops;
        c.ride  = ride;
        cmd_queue.push_back(c);
        if (act == srt_pkg::ACT_INSERT && gen_keys.size() < srt_pkg::TABLE_DEPTH) begin
            gen_keys.push_back(key);
        end else if (act == srt_pkg::ACT_DELETE) begin
            idx = -1;
            foreach (gen_keys[j])
                if (idx < 0 && gen_keys[j] == key)
                    idx = j;
            if (idx >= 0)
                gen_keys.delete(idx);
        end
    endfunction

    // Keys: many small ones so duplicates and hits are common, some extremes
    function automatic logic [srt_pkg::KEYP_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return srt_pkg::KEYP_W'($urandom_range(0, 15));
        if (roll == 3)
            return ($urandom_range(0, 1) == 0) ? '0 : '1;
        if (roll == 4)
            return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
        return srt_pkg::KEYP_W'($urandom);
    endfunction

    // Stimulus, reset and end of run
    initial begin
        logic [srt_pkg::ACT_W-1:0]  act;
        logic [srt_pkg::KEYP_W-1:0] key;
        bit                         filling;
        int                         mode_left;
        int                         roll;
        int                         ins_pct;
        int                         del_pct;
        int                         n;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = '0;
        i_key        = '0;
        i_stop_count = '0;
        i_ride_time  = '0;
        drive_on     = 1'b0;
        gap_left     = 0;
        burst_left   = 1;
        tbl_fill     = 0;
        foreach (tbl_key[j]) begin
            tbl_key[j]   = '0;
            tbl_stops[j] = '0;
            tbl_ride[j]  = '0;
        end

        // Directed: empty table cases, extremes, duplicates, misses, full table
        queue_cmd(srt_pkg::ACT_DUMP,   16'h0000, 8'h00, 16'h0000);
        queue_cmd(srt_pkg::ACT_DELETE, 16'h0042, 8'h00, 16'h0000);
        queue_cmd(ACT_UNUSED,          16'hFFFF, 8'hFF, 16'hFFFF);
        queue_cmd(srt_pkg::ACT_INSERT, 16'h8000, 8'h55, 16'hAAAA);
        queue_cmd(srt_pkg::ACT_INSERT, 16'h0000, 8'h00, 16'h0000);
        queue_cmd(srt_pkg::ACT_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_cmd(srt_pkg::ACT_INSERT, 16'h8000, 8'hAA, 16'h5555);
        queue_cmd(srt_pkg::ACT_DUMP,   16'h0000, 8'h00, 16'h0000);
        queue_cmd(srt_pkg::ACT_DELETE, 16'h8000, 8'h00, 16'h0000);
        queue_cmd(srt_pkg::ACT_DELETE, 16'h1234, 8'h00, 16'h0000);
        for (n = 0; n < srt_pkg::TABLE_DEPTH - 3; n++)
            queue_cmd(srt_pkg::ACT_INSERT, pick_key(), srt_pkg::STOPS_W'($urandom),
                      srt_pkg::TIME_W'($urandom));
        queue_cmd(srt_pkg::ACT_INSERT, 16'h4000, 8'h12, 16'h3456);
        queue_cmd(srt_pkg::ACT_DUMP,   16'h0000, 8'h00, 16'h0000);

        // Random: alternate filling and draining stretches so both ends are hit
        filling   = 1'b0;
        mode_left = 0;
        n = 0;
        while (n < RANDOM_CMDS) begin
            if (mode_left == 0) begin
                filling   = !filling;
                mode_left = $urandom_range(20, 50);
            end
            mode_left--;
            roll    = $urandom_range(0, 99);
            ins_pct = filling ? 65 : 20;
            del_pct = filling ? 20 : 65;
            if (roll < ins_pct)
                act = srt_pkg::ACT_INSERT;
            else if (roll < ins_pct + del_pct)
                act = srt_pkg::ACT_DELETE;
            else if (roll < 97)
                act = srt_pkg::ACT_DUMP;
            else
                act = ACT_UNUSED;
            key = pick_key();
            if (act == srt_pkg::ACT_DELETE && gen_keys.size() != 0 &&
                $urandom_range(0, 99) < 85)
                key = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
            queue_cmd(act, key, srt_pkg::STOPS_W'($urandom), srt_pkg::TIME_W'($urandom));
            if (act != ACT_UNUSED)
                n++;
        end
        total_cmds = cmd_queue.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_on = 1'b1;

        while (taken_count < total_cmds)
            @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d commands: %0d inserts (%0d full), %0d deletes (%0d misses),",
                 total_cmds, n_insert, n_full, n_delete, n_miss);
        $display("  %0d dumps (%0d rows, %0d empty), %0d ignored, peak fill %0d, %0d checked",
                 n_dump, n_rows, n_empty_dump, n_ignored, peak_fill, checked_count);
        if (err_count == 0) begin
            $display("sorted_record_table_unit: match");
        end else begin
            $display("%0d errors", err_count);
            $display("sorted_record_table_unit: mismatch");
        end
        $finish;
    end

    // Driver: offers queued words in bursts, with random gaps between bursts
    always @(negedge i_clk) begin
        t_cmd c;
        if (!drive_on) begin
            start <= 1'b0;
        end else if (start && taken_count != issued_count) begin
            // word still on offer
        end else if (gap_left > 0) begin
            gap_left--;
            start        <= 1'b0;
            i_action     <= srt_pkg::ACT_W'($urandom);
            i_key        <= srt_pkg::KEYP_W'($urandom);
            i_stop_count <= srt_pkg::STOPS_W'($urandom);
            i_ride_time  <= srt_pkg::TIME_W'($urandom);
        end else if (cmd_queue.size() != 0) begin
            c = cmd_queue.pop_front();
            issued_count++;
            start        <= 1'b1;
            i_action     <= c.act;
            i_key        <= c.key;
            i_stop_count <= c.stops;
            i_ride_time  <= c.ride;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 6);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: predicts on each accepted command, checks each result word
    always @(posedge i_clk) begin
        t_cmd    c;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            stall_cycles++;
            if (start && !busy) begin
                c.act   = i_action;
                c.key   = i_key;
                c.stops = i_stop_count;
                c.ride  = i_ride_time;
                predict_table_op(c);
                taken_count++;
                stall_cycles = 0;
            end
            if (o_valid) begin
                stall_cycles = 0;
                got = {o_status, o_out_key, o_out_stops, o_out_time, o_entries_held, o_last};
                if (pending_results.size() == 0) begin
                    flag_error($sformatf(
                        "unexpected word st=%0d key=%h stops=%h time=%h held=%0d last=%b",
                        got.status, got.key, got.stops, got.ride, got.held, got.last));
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (got.status !== want.status || got.key !== want.key ||
                        got.stops !== want.stops || got.ride !== want.ride ||
                        got.held !== want.held || got.last !== want.last)
                        flag_error({$sformatf(
                            "word %0d: want st=%0d key=%h stops=%h time=%h held=%0d last=%b",
                            checked_count, want.status, want.key, want.stops,
                            want.ride, want.held, want.last),
                            $sformatf(", got st=%0d key=%h stops=%h time=%h held=%0d last=%b",
                            got.status, got.key, got.stops, got.ride, got.held, got.last)});
                end
            end
            // nothing accepted on either side for too long
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress, %0d words outstanding",
                         pending_results.size());
                $display("sorted_record_table_unit: mismatch");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
hw/rtl/srt_pkg.sv
hw/rtl/srt_ram.sv
hw/rtl/srt_cmp.sv
hw/rtl/sorted_record_table_unit.sv
dv/testbench.sv
